[rtl/htsc_pkg.sv]
// package: types, constants and the sine series of the heading turn speed controller
package htsc_pkg;

    localparam int HEAD_W  = 16;
    localparam int SPEED_W = 15;
    localparam int DRIVE_W = 16;
    localparam int TGT_W   = 32;
    localparam int DIFF_W  = 34;
    localparam int CDEG_W  = 17;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_DEGREES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 2'd2;

    localparam int ANG_QUARTER  = 9000;
    localparam int ANG_FULL     = 36000;
    localparam int STOP_MARGIN  = 75;
    localparam int RAMP_MARGIN  = 200;
    localparam int WRAP_LOW     = 1000;
    localparam int WRAP_HIGH    = 35000;
    localparam int TURN_FULL    = 360;
    localparam int CDEG_PER_DEG = 100;
    localparam int IDX_SHIFT    = 28;

    localparam int          MOD360_SHIFT = 32;
    localparam logic [23:0] MOD360_MUL   = 24'd11930465;

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TURN,
        PH_SETTLE,
        PH_CHECK
    } t_phase;

    typedef struct packed {
        logic              begin_req;
        logic [HEAD_W-1:0] heading;
        logic              wheels_zero;
        logic              abort_request;
    } t_sample;

    typedef struct packed {
        logic upd;
        logic drive;
        logic use_sine;
        logic sat;
        logic ccw;
        logic done;
        logic aborted;
    } t_stage;

    typedef struct packed {
        logic                      drive_update;
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      turn_done;
        logic                      turn_aborted;
    } t_result;

    function automatic logic [15:0] sine_series(input logic [63:0] x);
        logic signed [63:0] sum;
        logic signed [63:0] q;
        logic [63:0]        t;
        sum = signed'(x);
        t   = x;
        for (int k = 1; k <= 6; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (k)
                1:       t = t / 64'd6;
                2:       t = t / 64'd20;
                3:       t = t / 64'd42;
                4:       t = t / 64'd72;
                5:       t = t / 64'd110;
                6:       t = t / 64'd156;
                default: t = t;
            endcase
            if ((k & 1) == 1) begin
                sum = sum - signed'(t);
            end else begin
                sum = sum + signed'(t);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32768) begin
            q = 64'sd32768;
        end
        return q[15:0];
    endfunction

endpackage

[rtl/htsc_in_if.sv]
// interface: sample channel into the controller
interface htsc_in_if;
    logic               valid;
    logic               ready;
    logic               begin_req;
    logic [15:0]        heading;
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
    logic               abort_request;

    modport source (
        output valid, begin_req, heading, left_wheel_speed, right_wheel_speed, abort_request,
        input  ready
    );
    modport sink (
        input  valid, begin_req, heading, left_wheel_speed, right_wheel_speed, abort_request,
        output ready
    );
endinterface

[rtl/htsc_out_if.sv]
// interface: result channel out of the controller
interface htsc_out_if;
    logic               valid;
    logic               ready;
    logic               drive_update;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               turn_done;
    logic               turn_aborted;

    modport source (
        output valid, drive_update, left_drive, right_drive, turn_done, turn_aborted,
        input  ready
    );
    modport sink (
        input  valid, drive_update, left_drive, right_drive, turn_done, turn_aborted,
        output ready
    );
endinterface

[rtl/htsc_drive.sv]
// drive stage: sine profile lookup, span scaling and wheel sign assignment
module htsc_drive
    import htsc_pkg::*;
#(
    parameter int SINE_STEPS = 91
) (
    input  t_stage                          i_ctl,
    input  logic [$clog2(SINE_STEPS)-1:0]   i_idx,
    input  logic [SPEED_W-1:0]              i_min_speed,
    input  logic [SPEED_W-1:0]              i_max_speed,
    output t_result                         o_result
);

    localparam int IDX_W = $clog2(SINE_STEPS);

    logic [15:0]            w_sine [SINE_STEPS];
    logic [IDX_W-1:0]       w_sel;
    logic [15:0]            w_entry;
    logic [SPEED_W-1:0]     w_span;
    logic [SPEED_W+15:0]    w_prod;
    logic [SPEED_W-1:0]     w_share;
    logic [DRIVE_W-1:0]     w_spd;
    logic signed [DRIVE_W-1:0] w_pos;
    logic signed [DRIVE_W-1:0] w_neg;

    for (genvar g = 0; g < SINE_STEPS; g++) begin : g_tab
        localparam logic [63:0] ANGLE_Q30 = 64'(g) * Q30_HALF_PI / 64'(SINE_STEPS - 1);
        assign w_sine[g] = sine_series(ANGLE_Q30);
    end

    assign w_sel   = i_ctl.sat ? IDX_W'(SINE_STEPS - 1) : i_idx;
    assign w_entry = w_sine[w_sel];
    assign w_span  = (i_max_speed >= i_min_speed) ? (i_max_speed - i_min_speed) : '0;
    assign w_prod  = (SPEED_W+16)'(w_span) * (SPEED_W+16)'(w_entry);
    assign w_share = i_ctl.use_sine ? w_prod[SPEED_W+14:15] : '0;
    assign w_spd   = {1'b0, w_share} + {1'b0, i_min_speed};
    assign w_pos   = signed'(w_spd);
    assign w_neg   = -signed'(w_spd);

    always_comb begin
        o_result              = '0;
        o_result.drive_update = i_ctl.upd;
        o_result.turn_done    = i_ctl.done;
        o_result.turn_aborted = i_ctl.aborted;
        if (i_ctl.drive) begin
            o_result.left_drive  = i_ctl.ccw ? w_neg : w_pos;
            o_result.right_drive = i_ctl.ccw ? w_pos : w_neg;
        end
    end

endmodule

[rtl/heading_turn_speed_controller_core.sv]
// top level: heading turn speed controller with sample and result channels
// throughput: one sample word per cycle while the result channel is not stalled
// the turn state updates in a single stage
// the path is input register, state stage with index multiply, drive stage, output register
// reset: synchronous active low, clears phase, heading state and valid flags to zero
// the sine table is constant logic and needs no fill after reset
module heading_turn_speed_controller_core
    import htsc_pkg::*;
#(
    parameter int SINE_STEPS = 91
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    htsc_in_if.sink              i_in,
    htsc_out_if.source           o_out
);

    localparam int          IDX_W     = $clog2(SINE_STEPS);
    localparam logic [63:0] IDX_MUL   = (64'(SINE_STEPS - 1) * (64'd1 << IDX_SHIFT)
                                         + 64'(ANG_QUARTER - 1)) / 64'(ANG_QUARTER);
    localparam int          IDX_MUL_W = $clog2(IDX_MUL + 64'd1);

    // configuration
    logic [SPEED_W-1:0]       r_min_speed;
    logic [SPEED_W-1:0]       r_max_speed;
    logic signed [CDEG_W-1:0] r_turn_cdeg;
    logic                     r_turn_ccw;

    logic signed [CFG_W-1:0]  w_t;
    logic [CFG_W:0]           w_t_abs;
    logic [CFG_W+23:0]        w_q_prod;
    logic [6:0]               w_q;
    logic [CFG_W:0]           w_rem;
    logic signed [CDEG_W-1:0] w_t_red;
    logic signed [CDEG_W-1:0] w_cdeg;

    assign w_t      = signed'(i_cfg_data);
    assign w_t_abs  = w_t[CFG_W-1] ? (CFG_W+1)'(-{w_t[CFG_W-1], w_t}) : {1'b0, w_t};
    assign w_q_prod = {23'd0, w_t_abs} * {{CFG_W{1'b0}}, MOD360_MUL};
    assign w_q      = w_q_prod[MOD360_SHIFT+6:MOD360_SHIFT];
    assign w_rem    = w_t_abs - (CFG_W+1)'(w_q) * (CFG_W+1)'(TURN_FULL);

    always_comb begin
        if (w_t == CFG_W'(TURN_FULL) || w_t == -CFG_W'(TURN_FULL)) begin
            w_t_red = CDEG_W'(w_t);
        end else if (w_t[CFG_W-1]) begin
            w_t_red = -signed'(w_rem);
        end else begin
            w_t_red = signed'(w_rem);
        end
    end

    assign w_cdeg = w_t_red * CDEG_W'(CDEG_PER_DEG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= '0;
            r_max_speed <= '0;
            r_turn_cdeg <= '0;
            r_turn_ccw  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TURN_DEGREES: begin
                    r_turn_cdeg <= w_cdeg;
                    r_turn_ccw  <= !w_t_red[CDEG_W-1];
                end
                CFG_MIN_SPEED: r_min_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic    r_a_v;
    logic    r_b_v;
    logic    r_o_v;
    logic    w_o_free;
    logic    w_b_free;
    logic    w_a_free;
    logic    w_acc;
    logic    w_a_move;
    logic    w_b_move;

    assign w_o_free = !r_o_v || o_out.ready;
    assign w_b_free = !r_b_v || w_o_free;
    assign w_a_free = !r_a_v || w_b_free;
    assign w_acc    = i_in.valid && w_a_free;
    assign w_a_move = r_a_v && w_b_free;
    assign w_b_move = r_b_v && w_o_free;
    assign i_in.ready = w_a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_v <= i_in.valid;
            end
            if (w_b_free) begin
                r_b_v <= r_a_v;
            end
            if (w_o_free) begin
                r_o_v <= r_b_v;
            end
        end
    end

    // input register
    t_sample r_a;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a.begin_req     <= i_in.begin_req;
            r_a.heading       <= i_in.heading;
            r_a.wheels_zero   <= (i_in.left_wheel_speed == '0) && (i_in.right_wheel_speed == '0);
            r_a.abort_request <= i_in.abort_request;
        end
    end

    // turn state stage
    t_phase               r_phase;
    t_phase               n_phase;
    logic [HEAD_W-1:0]    r_prev;
    logic [HEAD_W-1:0]    n_prev;
    logic [TGT_W-1:0]     r_target;
    logic [TGT_W-1:0]     n_target;
    logic                 r_ccw;
    logic                 n_ccw;
    t_stage               r_b;
    t_stage               n_b;
    logic [IDX_W-1:0]     r_b_idx;
    logic [IDX_W-1:0]     n_b_idx;

    logic [TGT_W-1:0]          w_tgt_fix;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIFF_W-1:0]  w_e;
    logic [13+IDX_MUL_W:0]     w_idx_prod;

    always_comb begin
        w_tgt_fix = r_target;
        if (!r_ccw) begin
            if (r_a.heading > r_prev && r_prev < HEAD_W'(WRAP_LOW)) begin
                w_tgt_fix = r_target + TGT_W'(ANG_FULL);
            end
            w_diff = signed'({{(DIFF_W-HEAD_W){1'b0}}, r_a.heading})
                   - DIFF_W'(signed'(w_tgt_fix));
        end else begin
            if (r_a.heading < r_prev && r_prev > HEAD_W'(WRAP_HIGH)) begin
                w_tgt_fix = r_target - TGT_W'(ANG_FULL);
            end
            w_diff = DIFF_W'(signed'(w_tgt_fix))
                   - signed'({{(DIFF_W-HEAD_W){1'b0}}, r_a.heading});
        end
    end

    assign w_e        = w_diff - DIFF_W'(ANG_QUARTER);
    assign w_idx_prod = {{IDX_MUL_W{1'b0}}, w_e[13:0]} * {14'd0, IDX_MUL[IDX_MUL_W-1:0]};

    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_target = r_target;
        n_ccw    = r_ccw;
        n_b      = '0;
        n_b_idx  = IDX_W'(w_idx_prod >> IDX_SHIFT);
        if (r_a.begin_req) begin
            n_prev   = r_a.heading;
            n_target = {{(TGT_W-HEAD_W){1'b0}}, r_a.heading} + TGT_W'(r_turn_cdeg);
            n_ccw    = r_turn_ccw;
            n_phase  = PH_TURN;
        end else if (r_phase != PH_IDLE) begin
            n_target = w_tgt_fix;
            n_prev   = r_a.heading;
            n_b.ccw  = r_ccw;
            if (r_a.abort_request) begin
                n_b.aborted = 1'b1;
                n_phase     = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_TURN: begin
                        n_b.upd = 1'b1;
                        if (w_diff > DIFF_W'(STOP_MARGIN)) begin
                            n_b.drive    = 1'b1;
                            n_b.use_sine = w_e > DIFF_W'(RAMP_MARGIN);
                            n_b.sat      = w_e >= DIFF_W'(ANG_QUARTER);
                        end else begin
                            n_phase = PH_SETTLE;
                        end
                    end
                    PH_SETTLE, PH_CHECK: begin
                        if (r_a.wheels_zero) begin
                            if (r_phase == PH_CHECK) begin
                                n_b.done = 1'b1;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_phase = PH_CHECK;
                            end
                        end else begin
                            n_phase = PH_SETTLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_prev   <= '0;
            r_target <= '0;
            r_ccw    <= 1'b0;
        end else if (w_a_move) begin
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_target <= n_target;
            r_ccw    <= n_ccw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_b     <= n_b;
            r_b_idx <= n_b_idx;
        end
    end

    // drive stage and output register
    t_result w_result;
    t_result r_o;

    htsc_drive #(
        .SINE_STEPS (SINE_STEPS)
    ) u_drive (
        .i_ctl       (r_b),
        .i_idx       (r_b_idx),
        .i_min_speed (r_min_speed),
        .i_max_speed (r_max_speed),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_o <= w_result;
        end
    end

    assign o_out.valid        = r_o_v;
    assign o_out.drive_update = r_o.drive_update;
    assign o_out.left_drive   = r_o.left_drive;
    assign o_out.right_drive  = r_o.right_drive;
    assign o_out.turn_done    = r_o.turn_done;
    assign o_out.turn_aborted = r_o.turn_aborted;

endmodule

[test/tb_heading_turn_speed_controller_core.sv]
// testbench: heading turn speed controller core checked word by word against a local turn model
module tb_heading_turn_speed_controller_core;
    import htsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int        SINE_LAST   = 90;
    localparam int        QUARTER_CD  = 9000;
    localparam int        FULL_CD     = 36000;
    localparam int        STOP_CD     = 75;
    localparam int        RAMP_CD     = 200;
    localparam int        WRAP_LO_CD  = 1000;
    localparam int        WRAP_HI_CD  = 35000;
    localparam int        FULL_TURN   = 360;
    localparam int        CD_PER_DEG  = 100;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int        RAND_GOAL   = 383;
    localparam int        HOLD_CYCLES = 400;

    typedef struct packed {
        logic               beg;
        logic [15:0]        heading;
        logic signed [15:0] lw;
        logic signed [15:0] rw;
        logic               abort;
    } t_sample_word;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    // sample rows: a heading, b left wheel, c right wheel; cfg rows: a turn, b min, c max
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        beg;
        logic        abort;
        logic        typed;
        t_result     exp;
    } t_dir_row;

    localparam t_result R_ZERO  = '0;
    localparam t_result R_DONE  = '{drive_update: 1'b0, left_drive: 16'sd0, right_drive: 16'sd0,
                                    turn_done: 1'b1, turn_aborted: 1'b0};
    localparam t_result R_ABORT = '{drive_update: 1'b0, left_drive: 16'sd0, right_drive: 16'sd0,
                                    turn_done: 1'b0, turn_aborted: 1'b1};

    localparam int DIR_ROWS = 36;
    localparam t_dir_row DIR_TAB [0:DIR_ROWS-1] = '{
        '{ROW_SAMPLE, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd35999, 16'h8000,  16'h7fff,  1'b0, 1'b1, 1'b1, R_ZERO},
        '{ROW_CFG,    16'd90,    16'd1000,  16'd32767, 1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd8930,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd8930,  16'd5,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd8930,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd8930,  16'd0,     16'd0,     1'b0, 1'b0, 1'b1, R_DONE},
        '{ROW_CFG,    16'h8000,  16'd0,     16'd32767, 1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd500,   16'd0,     16'd0,     1'b1, 1'b1, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd35900, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd35800, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd35800, 16'd0,     16'd0,     1'b0, 1'b1, 1'b1, R_ABORT},
        '{ROW_CFG,    16'd360,   16'd32767, 16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd100,   16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd100,   16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd35990, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd10,    16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'hffff,  16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'hffff,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_CFG,    16'd180,   16'd0,     16'd32767, 1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd0,     16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd8799,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd8800,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_CFG,    16'h7fff,  16'hffff,  16'h7fff,  1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd1000,  16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd1000,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_CFG,    16'hfe98,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd200,   16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd200,   16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_CFG,    16'd0,     16'd5,     16'd10,    1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd30000, 16'd0,     16'd0,     1'b1, 1'b0, 1'b1, R_ZERO},
        '{ROW_SAMPLE, 16'd30000, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd30000, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, R_ZERO},
        '{ROW_SAMPLE, 16'd30000, 16'd0,     16'd0,     1'b0, 1'b1, 1'b1, R_ABORT}
    };

    localparam logic [15:0] TURN_SPECIALS [0:8] = '{
        16'd0, 16'd360, 16'hfe98, 16'h7fff, 16'h8000, 16'd1, 16'hffff, 16'd359, 16'hfe99
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    htsc_in_if  sample_ch ();
    htsc_out_if drive_ch ();

    heading_turn_speed_controller_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (drive_ch)
    );

    // turn model state
    t_phase             drive_phase;
    logic [15:0]        last_head;
    logic [31:0]        target_cd;
    logic               turn_ccw;
    logic signed [15:0] reg_turn;
    logic [14:0]        reg_min;
    logic [14:0]        reg_max;
    logic [15:0]        sine_q15 [0:SINE_LAST];

    t_result drive_words_due [$];
    int      mismatch_count = 0;
    int      snd_idle_pct = 25;
    int      rcv_idle_pct = 45;
    int      hold_off_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] q15_sine(input longint unsigned x);
        longint unsigned t;
        longint          acc;
        longint          q;
        acc = longint'(x);
        t   = x;
        for (int k = 1; k <= 6; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        q = (acc + 16384) >>> 15;
        if (q > 32768) begin
            q = 32768;
        end
        return q[15:0];
    endfunction

    task automatic next_drive_word(input t_sample_word s, output t_result r);
        int     t;
        int     idx;
        longint diff;
        longint span;
        longint ex;
        longint spd;
        r = '0;
        if (s.beg) begin
            t = int'(reg_turn);
            if (t != FULL_TURN && t != -FULL_TURN) begin
                t = t % FULL_TURN;
            end
            last_head   = s.heading;
            target_cd   = 32'(longint'(s.heading) + longint'(t) * CD_PER_DEG);
            turn_ccw    = (t >= 0);
            drive_phase = PH_TURN;
        end else if (drive_phase != PH_IDLE) begin
            if (!turn_ccw) begin
                if (s.heading > last_head && last_head < 16'(WRAP_LO_CD)) begin
                    target_cd = target_cd + 32'(FULL_CD);
                end
                diff = longint'(s.heading) - longint'($signed(target_cd));
            end else begin
                if (s.heading < last_head && last_head > 16'(WRAP_HI_CD)) begin
                    target_cd = target_cd - 32'(FULL_CD);
                end
                diff = longint'($signed(target_cd)) - longint'(s.heading);
            end
            last_head = s.heading;
            if (s.abort) begin
                r.turn_aborted = 1'b1;
                drive_phase    = PH_IDLE;
            end else if (drive_phase == PH_TURN) begin
                r.drive_update = 1'b1;
                if (diff > STOP_CD) begin
                    span = (reg_max >= reg_min) ? longint'(reg_max) - longint'(reg_min) : 0;
                    ex   = diff - QUARTER_CD;
                    spd  = 0;
                    if (ex > RAMP_CD) begin
                        idx = (ex >= QUARTER_CD) ? SINE_LAST : int'((ex * SINE_LAST) / QUARTER_CD);
                        spd = (span * longint'(sine_q15[idx])) >>> 15;
                    end
                    spd = spd + longint'(reg_min);
                    r.left_drive  = turn_ccw ? 16'(-spd) : 16'(spd);
                    r.right_drive = turn_ccw ? 16'(spd) : 16'(-spd);
                end else begin
                    drive_phase = PH_SETTLE;
                end
            end else if (s.lw == 16'sd0 && s.rw == 16'sd0) begin
                if (drive_phase == PH_CHECK) begin
                    r.turn_done = 1'b1;
                    drive_phase = PH_IDLE;
                end else begin
                    drive_phase = PH_CHECK;
                end
            end else begin
                drive_phase = PH_SETTLE;
            end
        end
    endtask

    task automatic send_word(input t_sample_word w, input logic typed, input t_result exp);
        t_result r;
        while ($urandom_range(99) < snd_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.begin_req         <= w.beg;
        sample_ch.heading           <= w.heading;
        sample_ch.left_wheel_speed  <= w.lw;
        sample_ch.right_wheel_speed <= w.rw;
        sample_ch.abort_request     <= w.abort;
        do begin
            @(posedge i_clk);
        end while (!sample_ch.ready);
        next_drive_word(w, r);
        drive_words_due.push_back(typed ? exp : r);
    endtask

    task automatic drain_words();
        sample_ch.valid <= 1'b0;
        while (drive_words_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_regs(input logic [15:0] turn, input logic [15:0] mn,
                              input logic [15:0] mx);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TURN_DEGREES;
        i_cfg_data <= turn;
        @(posedge i_clk);
        reg_turn   = $signed(turn);
        i_cfg_idx  <= CFG_MIN_SPEED;
        i_cfg_data <= mn;
        @(posedge i_clk);
        reg_min    = mn[14:0];
        i_cfg_idx  <= CFG_MAX_SPEED;
        i_cfg_data <= mx;
        @(posedge i_clk);
        reg_max    = mx[14:0];
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_turn();
        case ($urandom_range(4))
            0: return 16'(int'($urandom_range(720)) - FULL_TURN);
            1: return $urandom_range(1) ? 16'($urandom_range(360, 300))
                                        : 16'(-int'($urandom_range(360, 300)));
            2: return 16'($urandom);
            default: return TURN_SPECIALS[$urandom_range(8)];
        endcase
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(2000));
        endcase
    endfunction

    task automatic noise_burst();
        t_sample_word w;
        int n;
        n = $urandom_range(6, 1);
        repeat (n) begin
            w.beg     = ($urandom_range(9) == 0);
            w.heading = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(35999));
            w.lw      = $urandom_range(1) ? 16'sd0 : 16'($urandom);
            w.rw      = $urandom_range(1) ? 16'sd0 : 16'($urandom);
            w.abort   = ($urandom_range(9) < 3);
            send_word(w, 1'b0, R_ZERO);
        end
    endtask

    task automatic run_turn(inout int count);
        t_sample_word w;
        int h;
        int n;
        int step;
        h         = $urandom_range(35999);
        w.beg     = 1'b1;
        w.heading = 16'(h);
        w.lw      = 16'($urandom);
        w.rw      = 16'($urandom);
        w.abort   = ($urandom_range(3) == 0);
        send_word(w, 1'b0, R_ZERO);
        count++;
        n = 0;
        while (drive_phase == PH_TURN && n < 150) begin
            step = ($urandom_range(3) == 0) ? $urandom_range(100) : $urandom_range(900);
            h = turn_ccw ? (h + step) % FULL_CD : (h + FULL_CD - step) % FULL_CD;
            w.beg     = ($urandom_range(99) == 0);
            w.heading = ($urandom_range(49) == 0) ? 16'($urandom) : 16'(h);
            w.lw      = 16'($urandom);
            w.rw      = 16'($urandom);
            w.abort   = ($urandom_range(99) < 2);
            send_word(w, 1'b0, R_ZERO);
            count++;
            n++;
        end
        n = 0;
        while (drive_phase != PH_IDLE && n < 40) begin
            w.beg     = 1'b0;
            w.heading = 16'((h + $urandom_range(40)) % FULL_CD);
            if ($urandom_range(99) < 55) begin
                w.lw = 16'sd0;
                w.rw = 16'sd0;
            end else begin
                w.lw = $urandom_range(1) ? 16'($urandom) : 16'sd0;
                w.rw = 16'($urandom);
            end
            w.abort = ($urandom_range(99) < 2);
            send_word(w, 1'b0, R_ZERO);
            count++;
            n++;
        end
    endtask

    // result side: check every accepted word, then pick next ready
    initial begin
        t_result got;
        t_result exp;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && drive_ch.valid && drive_ch.ready) begin
                got = '{drive_ch.drive_update, drive_ch.left_drive, drive_ch.right_drive,
                        drive_ch.turn_done, drive_ch.turn_aborted};
                if (drive_words_due.size() == 0) begin
                    $display("%0t unexpected word upd %0d l %0d r %0d done %0d abort %0d",
                             $time, got.drive_update, got.left_drive, got.right_drive,
                             got.turn_done, got.turn_aborted);
                    mismatch_count++;
                end else begin
                    exp = drive_words_due.pop_front();
                    if (got.drive_update !== exp.drive_update) begin
                        $display("%0t drive_update expected %0d actual %0d", $time,
                                 exp.drive_update, got.drive_update);
                        mismatch_count++;
                    end
                    if (got.left_drive !== exp.left_drive) begin
                        $display("%0t left_drive expected %0d actual %0d", $time,
                                 exp.left_drive, got.left_drive);
                        mismatch_count++;
                    end
                    if (got.right_drive !== exp.right_drive) begin
                        $display("%0t right_drive expected %0d actual %0d", $time,
                                 exp.right_drive, got.right_drive);
                        mismatch_count++;
                    end
                    if (got.turn_done !== exp.turn_done) begin
                        $display("%0t turn_done expected %0d actual %0d", $time,
                                 exp.turn_done, got.turn_done);
                        mismatch_count++;
                    end
                    if (got.turn_aborted !== exp.turn_aborted) begin
                        $display("%0t turn_aborted expected %0d actual %0d", $time,
                                 exp.turn_aborted, got.turn_aborted);
                        mismatch_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                drive_ch.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                drive_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        t_dir_row     row;
        t_sample_word w;
        int           count;
        int           turns;
        i_rst_n                     <= 1'b0;
        i_cfg_we                    <= 1'b0;
        i_cfg_idx                   <= CFG_TURN_DEGREES;
        i_cfg_data                  <= '0;
        sample_ch.valid             <= 1'b0;
        sample_ch.begin_req         <= 1'b0;
        sample_ch.heading           <= '0;
        sample_ch.left_wheel_speed  <= '0;
        sample_ch.right_wheel_speed <= '0;
        sample_ch.abort_request     <= 1'b0;
        drive_ch.ready              <= 1'b0;
        drive_phase = PH_IDLE;
        last_head   = '0;
        target_cd   = '0;
        turn_ccw    = 1'b0;
        reg_turn    = '0;
        reg_min     = '0;
        reg_max     = '0;
        for (int i = 0; i <= SINE_LAST; i++) begin
            sine_q15[i] = q15_sine(longint'(i) * HALF_PI_Q30 / SINE_LAST);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TAB[i];
            if (row.kind == ROW_CFG) begin
                drain_words();
                write_regs(row.a, row.b, row.c);
            end else begin
                w = '{row.beg, row.a, row.b, row.c, row.abort};
                send_word(w, row.typed, row.exp);
            end
        end

        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin
                    snd_idle_pct = 25;
                    rcv_idle_pct = 45;
                end
                1: begin
                    snd_idle_pct = 45;
                    rcv_idle_pct = 25;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            count = 0;
            turns = 0;
            while (count < RAND_GOAL) begin
                if (turns % 4 == 0) begin
                    drain_words();
                    write_regs(pick_turn(), pick_speed(), pick_speed());
                end
                // long receiver hold-off while samples keep coming
                if (m == 0 && turns == 3) begin
                    hold_off_cycles = HOLD_CYCLES;
                end
                if ($urandom_range(99) < 15) begin
                    noise_burst();
                end else begin
                    run_turn(count);
                end
                turns++;
            end
        end

        drain_words();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
